[src/btd_pkg.sv]
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types, constants and the byte-level reverse map for the text decoder.
// ----------------------------------------------------------------------------
package btd_pkg;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // sequence length codes, zero means no sequence open
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THR  = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // table code point bounds
    localparam logic [10:0] CP_MIN_CANON = 11'h080;
    localparam logic [10:0] CP_LAT_LO    = 11'h0A1;
    localparam logic [10:0] CP_LAT_HI    = 11'h0AC;
    localparam logic [10:0] CP_LAT2_LO   = 11'h0AE;
    localparam logic [10:0] CP_LAT2_HI   = 11'h0FF;
    localparam logic [10:0] CP_SHIFT_LO  = 11'd256;
    localparam logic [10:0] CP_SHIFT_HI  = 11'd323;

    // one block of result bytes, last_idx is the index of the final byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } job_t;

    // front to queue write
    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    // queue status toward front and back
    typedef struct packed {
        logic           empty;
        logic           full;
        logic [QAW:0]   fill;
    } qstat_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } unmap_t;

    // sequence length from the lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_THR;
        end else begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    // decode a two-byte sequence and map it back through the byte table
    function automatic unmap_t unmap_two(input logic [7:0] b0, input logic [7:0] b1);
        unmap_t     r;
        logic [10:0] cp;
        logic [10:0] idx_w;
        logic [6:0]  idx;
        r.hit   = 1'b0;
        r.value = 8'h00;
        cp      = {b0[4:0], b1[5:0]};
        idx_w   = cp - CP_SHIFT_LO;
        idx     = idx_w[6:0];
        if (cp >= CP_MIN_CANON && b1[7:6] == 2'b10) begin
            if ((cp >= CP_LAT_LO && cp <= CP_LAT_HI) ||
                (cp >= CP_LAT2_LO && cp <= CP_LAT2_HI)) begin
                r.hit   = 1'b1;
                r.value = cp[7:0];
            end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
                r.hit = 1'b1;
                // control range, then delete through nbsp, then soft hyphen
                if (idx < 7'd33) begin
                    r.value = {1'b0, idx};
                end else if (idx < 7'd67) begin
                    r.value = 8'h7F + ({1'b0, idx} - 8'd33);
                end else begin
                    r.value = 8'hAD;
                end
            end
        end
        return r;
    endfunction

endpackage

[src/btd_front.sv]
// ----------------------------------------------------------------------------
// btd_front
// Gathers UTF-8 sequences and turns each finished one into a job of result
// bytes for the queue.
// ----------------------------------------------------------------------------
module btd_front import btd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output push_t      push
);

    logic [0:2][7:0] held_reg, held_next;
    logic [2:0]      len_reg, len_next;
    logic [1:0]      cnt_reg, cnt_next;

    logic [3:0][7:0] raw;
    logic [2:0]      lead;
    logic            complete;
    unmap_t          um;

    // candidate raw bytes, the current byte follows the held ones
    always_comb begin
        raw[0] = held_reg[0];
        raw[1] = (cnt_reg > 2'd1) ? held_reg[1] : in_byte;
        raw[2] = (cnt_reg > 2'd2) ? held_reg[2] : in_byte;
        raw[3] = in_byte;
    end

    assign lead     = lead_length(in_byte);
    assign complete = (({1'b0, cnt_reg} + 3'd1) >= len_reg);
    assign um       = unmap_two(held_reg[0], in_byte);

    // sequence assembly
    always_comb begin
        held_next = held_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        push      = '0;
        if (accept) begin
            if (len_reg == LEN_NONE) begin
                if (lead == LEN_ONE || end_of_text) begin
                    push.valid             = 1'b1;
                    push.job.bytes[0]      = in_byte;
                    push.job.last_idx      = 2'd0;
                end else begin
                    held_next[0] = in_byte;
                    cnt_next     = 2'd1;
                    len_next     = lead;
                end
            end else if (complete) begin
                len_next   = LEN_NONE;
                cnt_next   = 2'd0;
                push.valid = 1'b1;
                if (len_reg == LEN_TWO && um.hit) begin
                    push.job.bytes[0] = um.value;
                    push.job.last_idx = 2'd0;
                end else begin
                    push.job.bytes    = raw;
                    push.job.last_idx = cnt_reg;
                end
            end else if (end_of_text) begin
                // flush the unfinished sequence raw
                len_next          = LEN_NONE;
                cnt_next          = 2'd0;
                push.valid        = 1'b1;
                push.job.bytes    = raw;
                push.job.last_idx = cnt_reg;
            end else begin
                held_next[cnt_reg] = in_byte;
                cnt_next           = cnt_reg + 2'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_NONE;
            cnt_reg <= 2'd0;
        end else begin
            len_reg <= len_next;
            cnt_reg <= cnt_next;
        end
        held_reg <= held_next;
    end

endmodule

[src/btd_fifo.sv]
// ----------------------------------------------------------------------------
// btd_fifo
// Short job queue that decouples the front from the output side.
// ----------------------------------------------------------------------------
module btd_fifo import btd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  push_t  push,
    input  logic   pop,
    output job_t   head,
    output qstat_t stat
);

    job_t           mem [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   fill_reg, fill_next;

    // pointer and fill update
    always_comb begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push.valid) begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = rd_reg + 1'b1;
        end
        case ({push.valid, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_reg] <= push.job;
        end
    end

    assign head       = mem[rd_reg];
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == QDEPTH[QAW:0]);
    assign stat.fill  = fill_reg;

endmodule

[src/btd_back.sv]
// ----------------------------------------------------------------------------
// btd_back
// Sends the bytes of queued jobs one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module btd_back import btd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head,
    input  qstat_t     stat,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       busy_reg, busy_next;
    job_t       job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign last = (idx_reg == job_reg.last_idx);

    // load the next job when idle or when the final byte leaves
    assign pop = !stat.empty && (!busy_reg || (m_tready && last));

    always_comb begin
        busy_next = busy_reg;
        job_next  = job_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            job_next  = head;
            idx_next  = 2'd0;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        job_reg <= job_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.bytes[idx_reg];
    assign m_tlast  = last;

endmodule

[src/byte_level_text_decoder.sv]
// ----------------------------------------------------------------------------
// byte_level_text_decoder
// Reverse byte map of byte-level BPE text: UTF-8 sequences back to bytes.
// ----------------------------------------------------------------------------
// Input items are text bytes on s_tdata; s_tlast marks the final byte of the
// text and flushes an unfinished sequence raw. Each output item is one byte
// on m_tdata; m_tlast marks the last byte caused by one input item.
// A single input byte gives zero to four output bytes.
// Throughput: one input item per cycle while the job queue has room; the
// output side sends one byte per cycle while m_tready is high, so the
// four-entry job queue absorbs input while a raw flush of n bytes goes out.
// The first byte of a job passes through the job queue and then the output
// job register before it is valid on m_tdata.
// When m_tready is low, bytes wait in the output register and the queue;
// s_tready falls only once the queue holds four jobs.
// Reset clears the open sequence, the queue and the output valid state; the
// block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
module byte_level_text_decoder import btd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);

    logic   accept;
    push_t  push;
    job_t   head;
    qstat_t stat;
    logic   pop;

    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;

    btd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_text (s_tlast),
        .push        (push)
    );

    btd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    btd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // queue never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fill <= QDEPTH[QAW:0])
        else $error("job queue fill above depth");

    // a job is only taken from a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty job queue");

    // with nothing queued, the final byte of a job leaves the output idle
    a_drain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && stat.empty) |=> !m_tvalid)
        else $error("output valid without a queued job");

endmodule

[test/byte_level_text_decoder_tb.sv]
// ----------------------------------------------------------------------------
// byte_level_text_decoder_tb
// Self-checking bench for the byte-level text decoder.
// ----------------------------------------------------------------------------
// Text bytes are streamed into the decoder and each result byte is compared
// with a behavioral prediction. The prediction keeps its own open-sequence
// state and a reverse byte table built at time zero. A short directed list
// covers mapped pairs, overlong and broken pairs, longer sequences, stray
// continuation leads and end-of-text flushes. Random sequences follow, with
// bursts of idle cycles on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module byte_level_text_decoder_tb import btd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_ITEMS   = 40;
    localparam int HOLD_START   = 100;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 30;

    typedef struct {
        logic [7:0] in_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef enum int {
        KIND_MAPPED,
        KIND_ASCII,
        KIND_TWO_RAW,
        KIND_THREE,
        KIND_FOUR,
        KIND_NOISE
    } seq_kind_e;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_last

    // stimulus and expectation stores
    text_item_t text_q[$];
    out_item_t  decoded_q[$];

    // byte table: byte to code point and back
    logic [10:0] byte_to_point [0:255];
    logic [7:0]  point_to_byte [int];

    // predicted open sequence
    logic [7:0] held [0:2];
    logic [2:0] open_len;
    logic [1:0] held_n;

    int  items_total;
    int  items_taken;
    int  flushes_taken;
    int  bytes_checked;
    int  mismatches;
    int  blocked_cycles;
    int  cycles;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    bit  tail_phase;

    byte_level_text_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic add_text_byte(input logic [7:0] b, input logic eot);
        text_item_t it;
        it.in_byte     = b;
        it.end_of_text = eot;
        text_q = {text_q, it};
    endtask

    task automatic expect_byte(input logic [7:0] b, input logic last);
        out_item_t o;
        o.out_byte = b;
        o.run_last = last;
        decoded_q = {decoded_q, o};
    endtask

    task automatic clear_open();
        held[0]  = 8'h00;
        held[1]  = 8'h00;
        held[2]  = 8'h00;
        open_len = LEN_NONE;
        held_n   = 2'd0;
    endtask

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return LEN_ONE;
            8'b110?????: return LEN_TWO;
            8'b1110????: return LEN_THR;
            default:     return LEN_FOUR;
        endcase
    endfunction

    // predict the bytes that one accepted text byte releases
    task automatic decode_text_byte(input logic [7:0] b, input logic eot);
        logic [7:0]  run [0:3];
        int          n;
        logic [2:0]  len;
        logic [10:0] cp;
        // no sequence open, so this is a lead byte
        if (open_len == LEN_NONE || open_len > LEN_FOUR || held_n == 2'd0) begin
            len = lead_len(b);
            if (len == LEN_ONE || eot) begin
                clear_open();
                expect_byte(b, 1'b1);
                return;
            end
            held[0]  = b;
            held_n   = 2'd1;
            open_len = len;
            return;
        end
        n = held_n;
        for (int k = 0; k < n; k++) run[k] = held[k];
        run[n] = b;
        n++;
        len = open_len;
        // sequence complete or cut short by end of text
        if (n >= len || eot) begin
            clear_open();
            if (n >= len && len == LEN_TWO) begin
                cp = {run[0][4:0], run[1][5:0]};
                if (cp >= 11'h080 && run[1][7:6] == 2'b10 && point_to_byte.exists(int'(cp))) begin
                    expect_byte(point_to_byte[int'(cp)], 1'b1);
                    return;
                end
            end
            for (int k = 0; k < n; k++) expect_byte(run[k], k == n - 1);
            return;
        end
        held[n - 1] = b;
        held_n      = n[1:0];
    endtask

    // driver: offer pending items, predict on acceptance
    always @(posedge aclk) begin : drive_text
        text_item_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left   <= 0;
            tail_phase <= 1'b0;
            clear_open();
        end else begin
            tail_phase <= (text_q.size() < TAIL_ITEMS);
            if (s_tvalid && !s_tready) blocked_cycles++;
            if (s_tvalid && s_tready) begin
                decode_text_byte(s_tdata, s_tlast);
                if (s_tlast) flushes_taken++;
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                    gap_left <= $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    nxt = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.in_byte;
                    s_tlast  <= nxt.end_of_text;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the job queue fills
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0);
        end
    end

    // monitor: compare each output item with the oldest prediction
    always @(posedge aclk) begin : watch_out
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.out_byte) begin
                    report_mismatch($sformatf("byte %0d out_byte %02h, expected %02h",
                                              bytes_checked, m_tdata, want.out_byte));
                end
                if (m_tlast !== want.run_last) begin
                    report_mismatch($sformatf("byte %0d run_last %0b, expected %0b",
                                              bytes_checked, m_tlast, want.run_last));
                end
            end
            bytes_checked++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                     decoded_q.size());
            $display("** byte_level_text_decoder: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int          next_point;
        int          directed_n;
        int          r;
        int          len;
        logic        eot;
        logic [7:0]  target;
        logic [10:0] cp;
        logic [7:0]  seq [0:3];
        seq_kind_e   kind;

        // byte table: printable bytes keep their value, the rest shift up
        next_point = 256;
        for (int b = 0; b < 256; b++) begin
            if ((b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || b >= 8'hAE) begin
                byte_to_point[b] = 11'(b);
            end else begin
                byte_to_point[b] = 11'(next_point);
                next_point++;
            end
            point_to_byte[int'(byte_to_point[b])] = 8'(b);
        end

        // directed: single bytes, including one with end of text
        add_text_byte(8'h00, 1'b0);
        add_text_byte(8'h7F, 1'b1);
        // mapped pairs: latin range, first shifted, soft hyphen, delete
        add_text_byte(8'hC2, 1'b0); add_text_byte(8'hA1, 1'b0);
        add_text_byte(8'hC4, 1'b0); add_text_byte(8'h80, 1'b0);
        add_text_byte(8'hC5, 1'b0); add_text_byte(8'h83, 1'b0);
        add_text_byte(8'hC4, 1'b0); add_text_byte(8'hA1, 1'b0);
        // overlong pair and pair with a bad second byte
        add_text_byte(8'hC1, 1'b0); add_text_byte(8'h81, 1'b0);
        add_text_byte(8'hC3, 1'b0); add_text_byte(8'h41, 1'b0);
        // three- and four-byte sequences pass raw
        add_text_byte(8'hE2, 1'b0); add_text_byte(8'h82, 1'b0); add_text_byte(8'hAC, 1'b0);
        add_text_byte(8'hF0, 1'b0); add_text_byte(8'h9F, 1'b0);
        add_text_byte(8'h98, 1'b0); add_text_byte(8'h80, 1'b0);
        // stray continuation as lead, with an all-ones byte inside
        add_text_byte(8'h80, 1'b0); add_text_byte(8'hFF, 1'b0);
        add_text_byte(8'h41, 1'b0); add_text_byte(8'h42, 1'b0);
        // end of text mid-sequence, on a lead, and completing a pair
        add_text_byte(8'hE2, 1'b0); add_text_byte(8'h82, 1'b1);
        add_text_byte(8'hC3, 1'b1);
        add_text_byte(8'hC3, 1'b0); add_text_byte(8'hBF, 1'b1);
        directed_n = text_q.size();

        // random sequences, mostly well formed
        while (text_q.size() < directed_n + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45)      kind = KIND_MAPPED;
            else if (r < 60) kind = KIND_ASCII;
            else if (r < 70) kind = KIND_TWO_RAW;
            else if (r < 80) kind = KIND_THREE;
            else if (r < 90) kind = KIND_FOUR;
            else             kind = KIND_NOISE;
            for (int k = 1; k < 4; k++) begin
                seq[k] = ($urandom_range(0, 3) != 0) ? 8'(8'h80 + $urandom_range(0, 63))
                                                      : 8'($urandom_range(0, 255));
            end
            case (kind)
                KIND_MAPPED: begin
                    target = 8'($urandom_range(0, 255));
                    cp     = byte_to_point[target];
                    if (cp < 11'h080) begin
                        seq[0] = cp[7:0];
                        len    = 1;
                    end else begin
                        seq[0] = {3'b110, cp[10:6]};
                        seq[1] = {2'b10, cp[5:0]};
                        len    = 2;
                    end
                end
                KIND_ASCII: begin
                    seq[0] = 8'($urandom_range(0, 127));
                    len    = 1;
                end
                KIND_TWO_RAW: begin
                    seq[0] = 8'(8'hC0 + $urandom_range(0, 31));
                    seq[1] = 8'($urandom_range(0, 255));
                    len    = 2;
                end
                KIND_THREE: begin
                    seq[0] = 8'(8'hE0 + $urandom_range(0, 15));
                    len    = 3;
                end
                KIND_FOUR: begin
                    seq[0] = ($urandom_range(0, 1) != 0) ? 8'(8'hF0 + $urandom_range(0, 15))
                                                          : 8'(8'h80 + $urandom_range(0, 63));
                    len    = 4;
                end
                default: begin
                    seq[0] = 8'($urandom_range(0, 255));
                    len    = 1;
                end
            endcase
            // occasionally cut the sequence short with end of text
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                len = int'($urandom_range(1, len - 1));
                eot = 1'b1;
            end else begin
                eot = ($urandom_range(0, 11) == 0);
            end
            for (int k = 0; k < len; k++) add_text_byte(seq[k], eot && (k == len - 1));
        end
        items_total = text_q.size();

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every item, then every predicted byte, then a short drain
        while (items_taken < items_total) @(posedge aclk);
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d text bytes (%0d with end of text), %0d output bytes checked",
                 items_taken, flushes_taken, bytes_checked);
        $display("input held off on %0d cycles, incl. a %0d-cycle receiver stall; %0d mismatches",
                 blocked_cycles, HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("** byte_level_text_decoder: PASSED **");
        end else begin
            $display("** byte_level_text_decoder: FAILED **");
        end
        $finish;
    end

endmodule
